// File: design/rgb_led_chain_serializer_top_assert.svh
// ----------------------------------------------------------------------------
// RGB LED chain serializer assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_CHAIN_SERIALIZER_TOP_ASSERT_SVH
`define RGB_LED_CHAIN_SERIALIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define RLCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
`define RLCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define RLCS_ASSERT(label, prop, msg)
`define RLCS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/rlcs_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED chain serializer package
// Shared types, codes and reset values of the LED chain serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package rlcs_pkg;

  localparam int LED_COUNT_DEFAULT = 3;
  localparam int BITS_PER_LED      = 24;
  localparam int COLOR_W           = 24;
  localparam int CFG_DATA_W        = 20;
  localparam int CFG_INDEX_W       = 3;
  localparam int COUNT_W           = 20;

  localparam logic [7:0]  ONE_HIGH_RESET   = 8'd12;
  localparam logic [7:0]  ZERO_HIGH_RESET  = 8'd4;
  localparam logic [7:0]  BIT_PERIOD_RESET = 8'd16;
  localparam logic [15:0] GAP_RESET        = 16'd1280;
  localparam logic [19:0] SETTLE_RESET     = 20'd16000;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET_LED   = 3'd1,
    OP_SET_ALL   = 3'd2,
    OP_UPDATE    = 3'd3,
    OP_SHOW      = 3'd4,
    OP_POWER_OFF = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_RESET  = 3'd2,
    PH_BITS   = 3'd3,
    PH_LATCH  = 3'd4
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ONE_HIGH   = 3'd0,
    CFG_ZERO_HIGH  = 3'd1,
    CFG_BIT_PERIOD = 3'd2,
    CFG_GAP        = 3'd3,
    CFG_SETTLE     = 3'd4
  } cfg_index_t;

endpackage

`default_nettype wire

// File: design/rlcs_ram.sv
// ----------------------------------------------------------------------------
// RGB LED chain serializer RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 3
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/rgb_led_chain_serializer_top.sv
// ----------------------------------------------------------------------------
// RGB LED chain serializer top level
// Drives a daisy-chained addressable RGB LED string from a color store.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while results are taken and no
// store sweep runs, since each tick moves the data line waveform by one tick
// and the color store RAM is prefetched one LED ahead. Set-all, power-off
// and an automatic power-off rewrite the whole store one entry per clock,
// and intake pauses until that sweep ends. After reset the same clearing
// pass runs before the first transaction is taken; configuration writes are
// taken at any time.
`default_nettype none

module rgb_led_chain_serializer_top #(
  parameter int LED_COUNT = rlcs_pkg::LED_COUNT_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [rlcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [rlcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [2:0]                          operation,
  input  wire logic [9:0]                          led_addr,
  input  wire logic [7:0]                          red,
  input  wire logic [7:0]                          green,
  input  wire logic [7:0]                          blue,
  input  wire logic [23:0]                         off_delay,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     data_level,
  output logic                                     power_enable,
  output logic                                     busy_res,
  output logic                                     accepted
);

  localparam int IDX_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int SWEEP_W = $clog2(LED_COUNT + 1);
  localparam int CW      = rlcs_pkg::COUNT_W;

  // Configuration registers.
  logic [7:0]  one_high_ticks;
  logic [7:0]  zero_high_ticks;
  logic [7:0]  bit_period_ticks;
  logic [15:0] gap_ticks;
  logic [19:0] settle_ticks;

  // Frame state.
  rlcs_pkg::phase_t frame_phase, frame_phase_next;
  logic [CW-1:0]    phase_count, phase_count_next;
  logic [4:0]       bit_position, bit_position_next;
  logic [IDX_W-1:0] led_position, led_position_next;
  logic             power_on, power_on_next;
  logic [23:0]      off_countdown, off_countdown_next;
  logic             off_armed, off_armed_next;
  logic             cut_after_frame, cut_after_frame_next;
  logic [rlcs_pkg::COLOR_W-1:0] cur_word, cur_word_next;

  // Store sweep.
  logic                         sweep_active;
  logic [SWEEP_W-1:0]           sweep_addr;
  logic [rlcs_pkg::COLOR_W-1:0] sweep_data;

  logic                         in_accept;
  logic                         busy;
  logic                         ok;
  logic                         store_we_op;
  logic                         fill_start;
  logic [rlcs_pkg::COLOR_W-1:0] fill_word;
  logic                         do_off;
  logic                         do_begin;
  logic [rlcs_pkg::COLOR_W-1:0] in_word;
  logic                         in_range;
  logic [CW:0]                  count_inc;
  logic [15:0]                  gap_eff;
  logic [7:0]                   per_eff;
  logic                         level_next;
  logic                         bit_value;
  logic [7:0]                   high_ticks;
  logic [4:0]                   bit_select;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [rlcs_pkg::COLOR_W-1:0] ram_wdata;
  logic [IDX_W-1:0]             ram_raddr;
  logic [rlcs_pkg::COLOR_W-1:0] ram_rdata;
  logic [IDX_W:0]               led_plus;

  assign in_ready  = !sweep_active && (!out_valid || out_ready);
  assign in_accept = in_valid && in_ready;
  assign busy      = (frame_phase != rlcs_pkg::PH_IDLE);
  assign in_word   = {red, green, blue};
  assign in_range  = ({1'b0, led_addr} < 11'(LED_COUNT));
  assign count_inc = {1'b0, phase_count} + {{CW{1'b0}}, 1'b1};
  assign gap_eff   = (gap_ticks == 16'd0) ? 16'd1 : gap_ticks;
  assign per_eff   = (bit_period_ticks == 8'd0) ? 8'd1 : bit_period_ticks;

  // Prefetch the color of the LED after the one being sent.
  assign led_plus  = {1'b0, led_position} + {{IDX_W{1'b0}}, 1'b1};
  assign ram_raddr = ((frame_phase == rlcs_pkg::PH_BITS) &&
                      (led_plus < (IDX_W+1)'(LED_COUNT))) ?
                     led_plus[IDX_W-1:0] : '0;

  assign ram_we    = sweep_active ? (sweep_addr < SWEEP_W'(LED_COUNT))
                                  : (in_accept && store_we_op);
  assign ram_waddr = sweep_active ? sweep_addr[IDX_W-1:0] : led_addr[IDX_W-1:0];
  assign ram_wdata = sweep_active ? sweep_data : in_word;

  rlcs_ram #(
    .WIDTH (rlcs_pkg::COLOR_W),
    .DEPTH (LED_COUNT)
  ) u_color_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state of the frame sequencer for the transaction at the input.
  always_comb begin
    frame_phase_next     = frame_phase;
    phase_count_next     = phase_count;
    bit_position_next    = bit_position;
    led_position_next    = led_position;
    power_on_next        = power_on;
    off_countdown_next   = off_countdown;
    off_armed_next       = off_armed;
    cut_after_frame_next = cut_after_frame;
    cur_word_next        = cur_word;
    ok                   = 1'b1;
    store_we_op          = 1'b0;
    fill_start           = 1'b0;
    fill_word            = '0;
    do_off               = 1'b0;
    do_begin             = 1'b0;

    if (busy) begin
      if (operation == rlcs_pkg::OP_TICK) begin
        unique case (frame_phase)
          rlcs_pkg::PH_SETTLE: begin
            if (count_inc >= {1'b0, settle_ticks}) begin
              frame_phase_next = rlcs_pkg::PH_RESET;
              phase_count_next = '0;
            end else begin
              phase_count_next = count_inc[CW-1:0];
            end
          end
          rlcs_pkg::PH_RESET: begin
            if (count_inc >= (CW+1)'(gap_eff)) begin
              frame_phase_next  = rlcs_pkg::PH_BITS;
              phase_count_next  = '0;
              bit_position_next = '0;
              led_position_next = '0;
              cur_word_next     = ram_rdata;
            end else begin
              phase_count_next = count_inc[CW-1:0];
            end
          end
          rlcs_pkg::PH_BITS: begin
            if (count_inc >= (CW+1)'(per_eff)) begin
              phase_count_next = '0;
              if (bit_position == 5'(rlcs_pkg::BITS_PER_LED - 1)) begin
                bit_position_next = '0;
                if (led_position == IDX_W'(LED_COUNT - 1)) begin
                  led_position_next = '0;
                  frame_phase_next  = rlcs_pkg::PH_LATCH;
                end else begin
                  led_position_next = led_plus[IDX_W-1:0];
                  cur_word_next     = ram_rdata;
                end
              end else begin
                bit_position_next = bit_position + 5'd1;
              end
            end else begin
              phase_count_next = count_inc[CW-1:0];
            end
          end
          rlcs_pkg::PH_LATCH: begin
            if (count_inc >= (CW+1)'(gap_eff)) begin
              frame_phase_next = rlcs_pkg::PH_IDLE;
              phase_count_next = '0;
              if (cut_after_frame) begin
                power_on_next        = 1'b0;
                cut_after_frame_next = 1'b0;
              end
            end else begin
              phase_count_next = count_inc[CW-1:0];
            end
          end
          default: begin
            frame_phase_next = rlcs_pkg::PH_IDLE;
            phase_count_next = '0;
          end
        endcase
      end else begin
        ok = 1'b0;
      end
    end else begin
      unique case (operation)
        rlcs_pkg::OP_TICK: begin
          if (off_armed) begin
            if (off_countdown == 24'd0) begin
              off_armed_next = 1'b0;
              do_off         = 1'b1;
            end else begin
              off_countdown_next = off_countdown - 24'd1;
            end
          end
        end
        rlcs_pkg::OP_SET_LED: begin
          store_we_op = in_range;
        end
        rlcs_pkg::OP_SET_ALL: begin
          fill_start = 1'b1;
          fill_word  = in_word;
        end
        rlcs_pkg::OP_UPDATE: begin
          do_begin = 1'b1;
        end
        rlcs_pkg::OP_SHOW: begin
          do_begin           = 1'b1;
          off_countdown_next = off_delay;
          off_armed_next     = 1'b1;
        end
        rlcs_pkg::OP_POWER_OFF: begin
          do_off = 1'b1;
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end

    if (do_off) begin
      fill_start = 1'b1;
      fill_word  = '0;
      if (power_on) begin
        do_begin             = 1'b1;
        cut_after_frame_next = 1'b1;
      end
    end

    if (do_begin) begin
      phase_count_next  = '0;
      bit_position_next = '0;
      led_position_next = '0;
      frame_phase_next  = rlcs_pkg::PH_RESET;
      if (!power_on) begin
        power_on_next = 1'b1;
        if (settle_ticks != 20'd0) begin
          frame_phase_next = rlcs_pkg::PH_SETTLE;
        end
      end
    end
  end

  // Data line level after the transaction.
  always_comb begin
    bit_select = 5'(rlcs_pkg::BITS_PER_LED - 1) - bit_position_next;
    bit_value  = cur_word_next[bit_select];
    high_ticks = bit_value ? one_high_ticks : zero_high_ticks;
    level_next = (frame_phase_next == rlcs_pkg::PH_BITS) &&
                 (phase_count_next < CW'(high_ticks));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_ticks   <= rlcs_pkg::ONE_HIGH_RESET;
      zero_high_ticks  <= rlcs_pkg::ZERO_HIGH_RESET;
      bit_period_ticks <= rlcs_pkg::BIT_PERIOD_RESET;
      gap_ticks        <= rlcs_pkg::GAP_RESET;
      settle_ticks     <= rlcs_pkg::SETTLE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rlcs_pkg::CFG_ONE_HIGH:   one_high_ticks   <= cfg_data[7:0];
        rlcs_pkg::CFG_ZERO_HIGH:  zero_high_ticks  <= cfg_data[7:0];
        rlcs_pkg::CFG_BIT_PERIOD: bit_period_ticks <= cfg_data[7:0];
        rlcs_pkg::CFG_GAP:        gap_ticks        <= cfg_data[15:0];
        rlcs_pkg::CFG_SETTLE:     settle_ticks     <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase     <= rlcs_pkg::PH_IDLE;
      phase_count     <= '0;
      bit_position    <= '0;
      led_position    <= '0;
      power_on        <= 1'b0;
      off_countdown   <= '0;
      off_armed       <= 1'b0;
      cut_after_frame <= 1'b0;
    end else if (in_accept) begin
      frame_phase     <= frame_phase_next;
      phase_count     <= phase_count_next;
      bit_position    <= bit_position_next;
      led_position    <= led_position_next;
      power_on        <= power_on_next;
      off_countdown   <= off_countdown_next;
      off_armed       <= off_armed_next;
      cut_after_frame <= cut_after_frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_word <= cur_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active <= 1'b1;
      sweep_addr   <= '0;
      sweep_data   <= '0;
    end else if (sweep_active) begin
      if (sweep_addr == SWEEP_W'(LED_COUNT)) begin
        sweep_active <= 1'b0;
      end else begin
        sweep_addr <= sweep_addr + {{(SWEEP_W-1){1'b0}}, 1'b1};
      end
    end else if (in_accept && fill_start) begin
      sweep_active <= 1'b1;
      sweep_addr   <= '0;
      sweep_data   <= fill_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_level   <= level_next;
      power_enable <= power_on_next;
      busy_res     <= (frame_phase_next != rlcs_pkg::PH_IDLE);
      accepted     <= ok;
    end
  end

`include "rgb_led_chain_serializer_top_assert.svh"

  `RLCS_ASSERT(a_level_only_in_frame, out_valid && data_level |-> busy_res, "Data line high outside a frame.")
  `RLCS_ASSERT(a_frame_needs_power, out_valid && busy_res |-> power_enable, "Frame in progress without chain power.")
  `RLCS_ASSERT(a_no_sweep_in_bits, (frame_phase == rlcs_pkg::PH_BITS) |-> !sweep_active, "Store sweep overlaps the bit phase.")
  `RLCS_ASSERT_ALWAYS(a_reset_clears, rst |=> sweep_active && !out_valid, "Reset did not start the clearing pass.")

endmodule

`default_nettype wire

// File: test/led_chain_tb_pkg.sv
// ----------------------------------------------------------------------------
// LED chain serializer scoreboard
// Keeps a cycle-level copy of the color store and the frame timing, predicts
// the line state after every command transaction and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package led_chain_tb_pkg;
  import rlcs_pkg::*;

  localparam int NUM_LEDS = LED_COUNT_DEFAULT;
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic data_level;
    logic power_enable;
    logic busy;
    logic accepted;
  } line_state_t;

  class led_chain_scoreboard;
    logic [7:0]  one_high;
    logic [7:0]  zero_high;
    logic [7:0]  bit_period;
    logic [15:0] gap_len;
    logic [19:0] settle_len;
    logic [23:0] colors [NUM_LEDS];
    bit          powered;
    bit          armed;
    bit          cut_pending;
    phase_t      phase;
    int unsigned phase_cnt;
    int unsigned bit_pos;
    int unsigned led_pos;
    logic [23:0] countdown;
    line_state_t expected_lines[$];
    int unsigned commands_taken;
    int unsigned mismatch_count;

    function new();
      one_high = ONE_HIGH_RESET;
      zero_high = ZERO_HIGH_RESET;
      bit_period = BIT_PERIOD_RESET;
      gap_len = GAP_RESET;
      settle_len = SETTLE_RESET;
      foreach (colors[i]) colors[i] = '0;
      powered = 1'b0;
      armed = 1'b0;
      cut_pending = 1'b0;
      phase = PH_IDLE;
      phase_cnt = 0;
      bit_pos = 0;
      led_pos = 0;
      countdown = '0;
      commands_taken = 0;
      mismatch_count = 0;
    endfunction

    function void write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_ONE_HIGH:   one_high = value[7:0];
        CFG_ZERO_HIGH:  zero_high = value[7:0];
        CFG_BIT_PERIOD: bit_period = value[7:0];
        CFG_GAP:        gap_len = value[15:0];
        CFG_SETTLE:     settle_len = value;
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction

    function void start_frame();
      phase_cnt = 0;
      bit_pos = 0;
      led_pos = 0;
      if (!powered) begin
        powered = 1'b1;
        if (settle_len != '0) begin
          phase = PH_SETTLE;
          return;
        end
      end
      phase = PH_RESET;
    endfunction

    function void fill_colors(logic [23:0] color);
      foreach (colors[i]) colors[i] = color;
    endfunction

    function void shut_down();
      fill_colors('0);
      if (powered) begin
        start_frame();
        cut_pending = 1'b1;
      end
    endfunction

    function void note_command(logic [2:0] op, logic [9:0] idx, logic [7:0] r,
                               logic [7:0] g, logic [7:0] b, logic [23:0] delay);
      int unsigned gap_eff;
      int unsigned period_eff;
      int unsigned high_len;
      bit          was_busy;
      logic [23:0] word;
      line_state_t state;
      gap_eff = (gap_len == '0) ? 1 : gap_len;
      period_eff = (bit_period == '0) ? 1 : bit_period;
      was_busy = busy();
      state.accepted = 1'b1;
      if (op == OP_TICK) begin
        if (was_busy) begin
          case (phase)
            PH_SETTLE: begin
              if (phase_cnt + 1 >= settle_len) begin
                phase = PH_RESET;
                phase_cnt = 0;
              end else begin
                phase_cnt++;
              end
            end
            PH_RESET: begin
              if (phase_cnt + 1 >= gap_eff) begin
                phase = PH_BITS;
                phase_cnt = 0;
                bit_pos = 0;
                led_pos = 0;
              end else begin
                phase_cnt++;
              end
            end
            PH_BITS: begin
              if (phase_cnt + 1 >= period_eff) begin
                phase_cnt = 0;
                bit_pos++;
                if (bit_pos >= BITS_PER_LED) begin
                  bit_pos = 0;
                  led_pos++;
                  if (led_pos >= NUM_LEDS) begin
                    led_pos = 0;
                    phase = PH_LATCH;
                  end
                end
              end else begin
                phase_cnt++;
              end
            end
            PH_LATCH: begin
              if (phase_cnt + 1 >= gap_eff) begin
                phase = PH_IDLE;
                phase_cnt = 0;
                if (cut_pending) begin
                  powered = 1'b0;
                  cut_pending = 1'b0;
                end
              end else begin
                phase_cnt++;
              end
            end
            default: begin
              phase = PH_IDLE;
              phase_cnt = 0;
            end
          endcase
        end else if (armed) begin
          if (countdown == '0) begin
            armed = 1'b0;
            shut_down();
          end else begin
            countdown--;
          end
        end
      end else if (op > OP_POWER_OFF || was_busy) begin
        state.accepted = 1'b0;
      end else begin
        case (op)
          OP_SET_LED: if (idx < NUM_LEDS) colors[idx] = {r, g, b};
          OP_SET_ALL: fill_colors({r, g, b});
          OP_UPDATE:  start_frame();
          OP_SHOW: begin
            start_frame();
            countdown = delay;
            armed = 1'b1;
          end
          OP_POWER_OFF: shut_down();
          default: ;
        endcase
      end

      state.data_level = 1'b0;
      if (phase == PH_BITS && led_pos < NUM_LEDS && bit_pos < BITS_PER_LED) begin
        word = colors[led_pos];
        high_len = word[23 - bit_pos] ? one_high : zero_high;
        state.data_level = (phase_cnt < high_len);
      end
      state.power_enable = powered;
      state.busy = busy();
      expected_lines.push_back(state);
      if (state.accepted) commands_taken++;
    endfunction

    function void check_line(logic level, logic power, logic busy_flag, logic ok);
      line_state_t want;
      line_state_t got;
      got = '{data_level: level, power_enable: power, busy: busy_flag, accepted: ok};
      if (expected_lines.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: level %0b power %0b busy %0b accepted %0b",
                   level, power, busy_flag, ok);
        return;
      end
      want = expected_lines.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display({"line state mismatch: expected level %0b power %0b busy %0b ",
                    "accepted %0b, got level %0b power %0b busy %0b accepted %0b"},
                   want.data_level, want.power_enable, want.busy, want.accepted,
                   got.data_level, got.power_enable, got.busy, got.accepted);
      end
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// LED chain serializer testbench
// Sends directed and random command transactions under several timing
// settings, with random stalls on both sides, and checks every result
// transaction against the scoreboard's prediction of the line state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rlcs_pkg::*;
  import led_chain_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD_CYCLES = 200;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [2:0]             operation;
  logic [9:0]             led_addr;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic [23:0]            off_delay;
  logic                   out_valid;
  logic                   out_ready;
  logic                   data_level;
  logic                   power_enable;
  logic                   busy_res;
  logic                   accepted;

  bit                     idle_enable = 1'b0;
  bit                     hold_request = 1'b0;
  int unsigned            commands_seen = 0;
  int unsigned            cycle_count = 0;
  led_chain_scoreboard    sb = new();

  always #1 clk = ~clk;

  rgb_led_chain_serializer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .led_addr     (led_addr),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .off_delay    (off_delay),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_level   (data_level),
    .power_enable (power_enable),
    .busy_res     (busy_res),
    .accepted     (accepted)
  );

  // Both handshakes are sampled in this one process so that prediction and
  // checking never race when a result comes out at the edge of its command.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left = 0;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && in_valid && in_ready) begin
        sb.note_command(operation, led_addr, red, green, blue, off_delay);
        commands_seen++;
      end
      if (!rst && out_valid && out_ready)
        sb.check_line(data_level, power_enable, busy_res, accepted);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      out_ready <= (hold_left == 0 && stall_left == 0);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic send_command(input logic [2:0] op, input logic [9:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [23:0] delay);
    int unsigned target;
    target = commands_seen + 1;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    led_addr <= idx;
    red <= r;
    green <= g;
    blue <= b;
    off_delay <= delay;
    do @(posedge clk); while (!in_ready);
    wait (commands_seen == target);
  endtask

  task automatic send_tick();
    send_command(OP_TICK, 10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 24'($urandom));
  endtask

  task automatic finish_frame();
    while (sb.busy()) send_tick();
  endtask

  task automatic power_down_chain();
    finish_frame();
    if (sb.powered) begin
      send_command(OP_POWER_OFF, 10'd0, 8'd0, 8'd0, 8'd0, 24'd0);
      finish_frame();
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] one, input logic [7:0] zero,
                           input logic [7:0] period, input logic [15:0] gap,
                           input logic [19:0] settle);
    cfg_index_t            regs[5];
    logic [CFG_DATA_W-1:0] vals[5];
    regs[0] = CFG_ONE_HIGH;
    regs[1] = CFG_ZERO_HIGH;
    regs[2] = CFG_BIT_PERIOD;
    regs[3] = CFG_GAP;
    regs[4] = CFG_SETTLE;
    vals[0] = 20'(one);
    vals[1] = 20'(zero);
    vals[2] = 20'(period);
    vals[3] = 20'(gap);
    vals[4] = settle;
    finish_frame();
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_register(regs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic configure_random();
    logic [7:0]  period;
    logic [7:0]  one;
    logic [19:0] settle;
    period = 8'($urandom_range(2, 3));
    one = ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom_range(1, period + 1));
    settle = ($urandom_range(0, 3) == 0) ? 20'd0 : 20'($urandom_range(1, 12));
    configure(one, 8'($urandom_range(1, period)), period, 16'($urandom_range(1, 6)),
              settle);
  endtask

  task automatic run_random(input int unsigned count, input bit frames_allowed,
                            input bit quiet);
    int unsigned goal;
    int unsigned block_end;
    int unsigned pick;
    logic [2:0]  op;
    logic [9:0]  idx;
    logic [23:0] delay;
    goal = sb.commands_taken + count;
    block_end = 0;
    while (sb.commands_taken < goal) begin
      if (sb.commands_taken >= block_end) begin
        block_end = sb.commands_taken + 64;
        idle_enable = !quiet && ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (sb.busy())
        op = (pick < 90) ? OP_TICK : 3'($urandom_range(OP_SET_LED, OP_UNUSED_B));
      else if (pick < 25)
        op = OP_TICK;
      else if (pick < 45)
        op = OP_SET_LED;
      else if (pick < 55)
        op = OP_SET_ALL;
      else if (pick < 70)
        op = OP_UPDATE;
      else if (pick < 80)
        op = OP_SHOW;
      else if (pick < 90)
        op = OP_POWER_OFF;
      else
        op = (pick < 95) ? OP_UNUSED_A : OP_UNUSED_B;
      if (!frames_allowed &&
          (op == OP_UPDATE || op == OP_SHOW || (op == OP_POWER_OFF && sb.powered)))
        op = OP_SET_ALL;
      idx = ($urandom_range(0, 7) != 0) ? 10'($urandom_range(0, NUM_LEDS - 1))
                                        : 10'($urandom);
      delay = ($urandom_range(0, 7) != 0) ? 24'($urandom_range(0, 15)) : 24'($urandom);
      send_command(op, idx, 8'($urandom), 8'($urandom), 8'($urandom), delay);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_ONE_HIGH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    operation <= OP_TICK;
    led_addr <= '0;
    red <= '0;
    green <= '0;
    blue <= '0;
    off_delay <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset timing is far too slow for frames, so only the store is touched here.
    send_command(OP_SET_LED, 10'd0, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF);
    send_command(OP_SET_LED, 10'(NUM_LEDS - 1), 8'h00, 8'h00, 8'h00, 24'h000000);
    send_command(OP_SET_LED, 10'(NUM_LEDS), 8'hA5, 8'h5A, 8'hC3, 24'hAAAAAA);
    send_command(OP_SET_LED, 10'h3FF, 8'h3C, 8'hC3, 8'h0F, 24'h555555);
    send_command(OP_SET_ALL, 10'h155, 8'h5A, 8'hA5, 8'h3C, 24'h0F0F0F);
    send_command(OP_UNUSED_A, 10'h2AA, 8'h11, 8'h22, 8'h33, 24'h123456);
    send_command(OP_UNUSED_B, 10'h0F0, 8'h44, 8'h55, 8'h66, 24'hFEDCBA);
    send_tick();
    send_command(OP_POWER_OFF, 10'd1, 8'h77, 8'h88, 8'h99, 24'd0);
    send_tick();

    // High width equal to the bit period.
    configure(8'd2, 8'd1, 8'd2, 16'd3, 20'd5);
    send_command(OP_SET_LED, 10'd0, 8'hFF, 8'h00, 8'h81, 24'd0);
    send_command(OP_SET_LED, 10'd1, 8'h00, 8'hFF, 8'h00, 24'd0);
    send_command(OP_SET_LED, 10'd2, 8'h80, 8'h01, 8'hFE, 24'd0);
    send_command(OP_UPDATE, 10'd0, 8'd0, 8'd0, 8'd0, 24'd0);
    send_command(OP_SET_LED, 10'd1, 8'h12, 8'h34, 8'h56, 24'd0);
    send_command(OP_UPDATE, 10'd0, 8'd0, 8'd0, 8'd0, 24'd0);
    send_command(OP_UNUSED_A, 10'd0, 8'd0, 8'd0, 8'd0, 24'd0);
    finish_frame();
    send_command(OP_UPDATE, 10'd0, 8'd0, 8'd0, 8'd0, 24'd0);
    send_command(OP_SHOW, 10'd0, 8'd0, 8'd0, 8'd0, 24'd2);
    finish_frame();
    send_command(OP_SHOW, 10'd0, 8'd0, 8'd0, 8'd0, 24'd0);
    finish_frame();
    send_tick();
    finish_frame();

    // High width above the bit period, and no settle wait after power-up.
    configure(8'd9, 8'd1, 8'd2, 16'd2, 20'd0);
    send_command(OP_SET_ALL, 10'd0, 8'h96, 8'h69, 8'hF0, 24'd0);
    send_command(OP_SHOW, 10'd0, 8'd0, 8'd0, 8'd0, 24'd3);
    finish_frame();
    repeat (5) send_tick();
    finish_frame();
    send_command(OP_POWER_OFF, 10'd0, 8'd0, 8'd0, 8'd0, 24'd0);
    finish_frame();

    configure_random();
    hold_request = 1'b1;
    run_random(30, 1'b1, 1'b1);
    run_random(80, 1'b1, 1'b0);
    configure_random();
    run_random(90, 1'b1, 1'b0);

    power_down_chain();
    configure(8'd255, 8'd255, 8'd255, 16'hFFFF, 20'hFFFFF);
    run_random(20, 1'b0, 1'b0);
    configure(8'd255, 8'd1, 8'd2, 16'd1, 20'd0);
    run_random(90, 1'b1, 1'b0);
    configure_random();
    run_random(90, 1'b1, 1'b0);
    configure_random();
    run_random(80, 1'b1, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
